// ===== rtl/core/sbww_pkg.sv =====
// Shared constants, codes and item types for the separable block window weighting block.
// Used by every module under rtl/core; depends on nothing.
package sbww_pkg;

  localparam int MAX_OVERLAP = 64;
  localparam int MAX_BLOCK   = 256;

  localparam int IDX_W      = 6;
  localparam int POS_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int OV_W       = 7;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [DATA_W-1:0] ONE_Q15 = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 8'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         weight_index;
    logic [DATA_W-1:0]        weight_value;
    logic signed [DATA_W-1:0] pixel;
    logic [IDX_W-1:0]         row_idx;
    logic                     row_one;
    logic [IDX_W-1:0]         col_idx;
    logic                     col_one;
    logic                     block_end;
    logic                     bypass;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] column_pos;
    logic [POS_W-1:0] row_pos;
  } front_status_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

// ===== rtl/core/sbww_front.sv =====
// Front end: configuration registers, raster position and taper classification.
// Builds one queue item per accepted request; depends on sbww_pkg.
module sbww_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbww_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbww_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                kind,
  input  logic [sbww_pkg::IDX_W-1:0]          weight_index,
  input  logic [sbww_pkg::DATA_W-1:0]         weight_value,
  input  logic signed [sbww_pkg::DATA_W-1:0]  pixel,
  input  logic                                queue_full,
  output logic                                push,
  output sbww_pkg::item_t                     push_item,
  output sbww_pkg::front_status_t             status
);

  typedef struct packed {
    logic [sbww_pkg::IDX_W-1:0] idx;
    logic                       one;
  } taper_t;

  function automatic taper_t taper_pick(input logic [sbww_pkg::POS_W-1:0]  pos,
                                        input logic [sbww_pkg::SIZE_W-1:0] size,
                                        input logic [sbww_pkg::OV_W-1:0]   ov);
    logic                        lo;
    logic                        hi;
    logic [sbww_pkg::SIZE_W:0]   reach;
    logic [sbww_pkg::SIZE_W-1:0] span;
    taper_t                      r;
    lo    = pos < {1'b0, ov};
    reach = {2'b0, pos} + {3'b0, ov};
    hi    = (reach > {1'b0, size}) && ({1'b0, pos} < size);
    span  = size - {1'b0, pos};
    r.idx = lo ? pos[sbww_pkg::IDX_W-1:0] : span[sbww_pkg::IDX_W-1:0];
    r.one = !(lo || hi);
    return r;
  endfunction

  logic [sbww_pkg::SIZE_W-1:0] block_width;
  logic [sbww_pkg::SIZE_W-1:0] block_height;
  logic [sbww_pkg::OV_W-1:0]   overlap;
  logic                        bypass;
  logic [sbww_pkg::POS_W-1:0]  column_pos;
  logic [sbww_pkg::POS_W-1:0]  row_pos;

  logic [sbww_pkg::SIZE_W-1:0] w;
  logic [sbww_pkg::SIZE_W-1:0] h;
  logic [sbww_pkg::OV_W-1:0]   ov;
  logic [sbww_pkg::SIZE_W-1:0] col_inc;
  logic [sbww_pkg::SIZE_W-1:0] row_inc;
  logic                        wrap_col;
  logic                        wrap_row;
  logic                        cfg_write;
  logic                        pixel_go;
  taper_t                      row_t;
  taper_t                      col_t;

  localparam logic [sbww_pkg::SIZE_W-1:0] SIZE_MAX = sbww_pkg::SIZE_W'(sbww_pkg::MAX_BLOCK);
  localparam logic [sbww_pkg::OV_W-1:0]   OV_MAX   = sbww_pkg::OV_W'(sbww_pkg::MAX_OVERLAP);

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign push      = in_valid && !queue_full;
  assign pixel_go  = push && (kind == sbww_pkg::KIND_PIXEL);

  always_comb begin
    priority if (block_width == '0) begin
      w = sbww_pkg::SIZE_W'(1);
    end else if (block_width > SIZE_MAX) begin
      w = SIZE_MAX;
    end else begin
      w = block_width;
    end
    priority if (block_height == '0) begin
      h = sbww_pkg::SIZE_W'(1);
    end else if (block_height > SIZE_MAX) begin
      h = SIZE_MAX;
    end else begin
      h = block_height;
    end
    ov       = (overlap > OV_MAX) ? OV_MAX : overlap;
    col_inc  = {1'b0, column_pos} + sbww_pkg::SIZE_W'(1);
    row_inc  = {1'b0, row_pos} + sbww_pkg::SIZE_W'(1);
    wrap_col = col_inc >= w;
    wrap_row = row_inc >= h;
    row_t    = taper_pick(row_pos, h, ov);
    col_t    = taper_pick(column_pos, w, ov);
  end

  always_comb begin
    push_item.kind         = kind;
    push_item.weight_index = weight_index;
    push_item.weight_value = weight_value;
    push_item.pixel        = pixel;
    push_item.row_idx      = row_t.idx;
    push_item.row_one      = row_t.one;
    push_item.col_idx      = col_t.idx;
    push_item.col_one      = col_t.one;
    push_item.block_end    = wrap_col && wrap_row;
    push_item.bypass       = bypass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= sbww_pkg::SIZE_W'(64);
      block_height <= sbww_pkg::SIZE_W'(64);
      overlap      <= sbww_pkg::OV_W'(16);
      bypass       <= 1'b0;
      column_pos   <= '0;
      row_pos      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbww_pkg::REG_BLOCK_WIDTH: begin
          block_width <= cfg_data[sbww_pkg::SIZE_W-1:0];
          column_pos  <= '0;
          row_pos     <= '0;
        end
        sbww_pkg::REG_BLOCK_HEIGHT: begin
          block_height <= cfg_data[sbww_pkg::SIZE_W-1:0];
          column_pos   <= '0;
          row_pos      <= '0;
        end
        sbww_pkg::REG_OVERLAP: begin
          overlap <= cfg_data[sbww_pkg::OV_W-1:0];
        end
        sbww_pkg::REG_BYPASS: begin
          bypass <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (pixel_go) begin
      if (wrap_col) begin
        column_pos <= '0;
        if (wrap_row) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_inc[sbww_pkg::POS_W-1:0];
        end
      end else begin
        column_pos <= col_inc[sbww_pkg::POS_W-1:0];
      end
    end
  end

  assign status.column_pos = column_pos;
  assign status.row_pos    = row_pos;

endmodule

// ===== rtl/core/sbww_queue.sv =====
// Short request queue between the front end and the weighting back end.
// Holds sbww_pkg::item_t entries in order; depends on sbww_pkg.
module sbww_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sbww_pkg::item_t         push_item,
  input  logic                    pop,
  output sbww_pkg::item_t         head,
  output sbww_pkg::queue_status_t status
);

  sbww_pkg::item_t                 slots [sbww_pkg::QUEUE_DEPTH];
  logic [sbww_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sbww_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sbww_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == sbww_pkg::QCNT_W'(sbww_pkg::QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + sbww_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + sbww_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + sbww_pkg::QCNT_W'(1);
        2'b01:   count <= count - sbww_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbww_back.sv =====
// Back end: edge weight table, factor product, pixel multiply, rounding and saturation.
// Drains sbww_queue in order and drives the result port; depends on sbww_pkg.
module sbww_back (
  input  logic                                clk,
  input  logic                                rst,
  input  sbww_pkg::item_t                     head,
  input  logic                                queue_empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sbww_pkg::DATA_W-1:0]  pixel_out,
  output logic                                block_end
);

  localparam int PROD_W = 2 * sbww_pkg::DATA_W + sbww_pkg::DATA_W + 1;
  localparam int FRAC_W = 2 * (sbww_pkg::DATA_W - 1);
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

  logic [sbww_pkg::DATA_W-1:0] weights [sbww_pkg::MAX_OVERLAP];

  logic                              en;
  logic                              v1;
  logic                              v2;
  logic                              v3;
  logic [sbww_pkg::DATA_W-1:0]       row_raw;
  logic [sbww_pkg::DATA_W-1:0]       col_raw;
  logic                              row_one1;
  logic                              col_one1;
  logic signed [sbww_pkg::DATA_W-1:0] px1;
  logic signed [sbww_pkg::DATA_W-1:0] px2;
  logic signed [sbww_pkg::DATA_W-1:0] px3;
  logic                              end1;
  logic                              end2;
  logic                              end3;
  logic                              byp1;
  logic                              byp2;
  logic                              byp3;
  logic [sbww_pkg::DATA_W-1:0]       row_f;
  logic [sbww_pkg::DATA_W-1:0]       col_f;
  logic [2*sbww_pkg::DATA_W-1:0]     f_mul;
  logic [2*sbww_pkg::DATA_W-1:0]     f2;
  logic signed [PROD_W-1:0]          prod_mul;
  logic signed [PROD_W-1:0]          prod3;
  logic signed [PROD_W-1:0]          rnd;
  logic signed [Q_W-1:0]             q;
  logic signed [sbww_pkg::DATA_W-1:0] res;

  assign en  = !out_valid || !out_stall;
  assign pop = en && !queue_empty;

  always_ff @(posedge clk) begin
    if (pop && (head.kind == sbww_pkg::KIND_LOAD)) begin
      weights[head.weight_index] <= head.weight_value;
    end
    if (en) begin
      row_raw <= weights[head.row_idx];
      col_raw <= weights[head.col_idx];
    end
  end

  always_comb begin
    row_f    = row_one1 ? sbww_pkg::ONE_Q15 : row_raw;
    col_f    = col_one1 ? sbww_pkg::ONE_Q15 : col_raw;
    f_mul    = {{sbww_pkg::DATA_W{1'b0}}, row_f} * {{sbww_pkg::DATA_W{1'b0}}, col_f};
    prod_mul = px2 * $signed({1'b0, f2});
    rnd      = prod3 + ROUND_HALF;
    q        = rnd[PROD_W-1:FRAC_W];
    priority if (byp3) begin
      res = px3;
    end else if (q > SAT_HI) begin
      res = SAT_HI[sbww_pkg::DATA_W-1:0];
    end else if (q < SAT_LO) begin
      res = SAT_LO[sbww_pkg::DATA_W-1:0];
    end else begin
      res = q[sbww_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_one1  <= head.row_one;
      col_one1  <= head.col_one;
      px1       <= head.pixel;
      end1      <= head.block_end;
      byp1      <= head.bypass;
      f2        <= f_mul;
      px2       <= px1;
      end2      <= end1;
      byp2      <= byp1;
      prod3     <= prod_mul;
      px3       <= px2;
      end3      <= end2;
      byp3      <= byp2;
      pixel_out <= res;
      block_end <= end3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop && (head.kind == sbww_pkg::KIND_PIXEL);
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

// ===== rtl/core/separable_block_window_weighting.sv =====
// Separable tapered window weighting of raster-order block pixels.
// Each accepted pixel passes the queue, table read, factor multiply, pixel multiply, and
// round and saturate registers in order; one item per cycle is sustained while out_stall
// is low, the back end popping at most one request from the four-entry queue per cycle.
// Reset: synchronous; clears position, queue and pipeline valids; the weight table
// holds no reset value and must be loaded before use.
module separable_block_window_weighting (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbww_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbww_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [sbww_pkg::IDX_W-1:0]          weight_index,
  input  logic [sbww_pkg::DATA_W-1:0]         weight_value,
  input  logic signed [sbww_pkg::DATA_W-1:0]  pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sbww_pkg::DATA_W-1:0]  pixel_out,
  output logic                                block_end
);

  logic                    push;
  logic                    pop;
  sbww_pkg::item_t         push_item;
  sbww_pkg::item_t         head;
  sbww_pkg::front_status_t fstat;
  sbww_pkg::queue_status_t qstat;

  assign in_stall = qstat.full;

  sbww_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .kind         (kind),
    .weight_index (weight_index),
    .weight_value (weight_value),
    .pixel        (pixel),
    .queue_full   (qstat.full),
    .push         (push),
    .push_item    (push_item),
    .status       (fstat)
  );

  sbww_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  sbww_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (qstat.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .block_end   (block_end)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty request queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= sbww_pkg::QCNT_W'(sbww_pkg::QUEUE_DEPTH))
    else $error("request queue count beyond depth");

  a_size_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == sbww_pkg::REG_BLOCK_WIDTH
      || cfg_index == sbww_pkg::REG_BLOCK_HEIGHT))
    |=> (fstat.column_pos == '0) && (fstat.row_pos == '0))
    else $error("block size write did not restart raster position");
`endif

endmodule
